/* design/mau_pkg.sv */
// Package for the modular arithmetic unit: payload structs, operation codes,
// sequencer states. No dependencies.
`default_nettype none
package mau_pkg;
	localparam int unsigned DEF_WIDTH = 32;

	typedef enum logic [2:0] {
		OP_REDUCE = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_MUL = 3'd3,
		OP_DIV = 3'd4, OP_NEG = 3'd5, OP_INV = 3'd6, OP_EQ = 3'd7
	} op_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic [63:0] signed_value;
	} in_item_t;

	typedef struct packed {
		logic [31:0] result;
		logic        is_equal;
		logic        error_code;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RDA, ST_RDB, ST_RDS, ST_DISP, ST_EDIV, ST_EMUL, ST_ECHK,
		ST_MUL, ST_DONE
	} state_t;
endpackage
`default_nettype wire

/* design/modular_arithmetic_unit.sv */
// Modular arithmetic unit: one residue operation per command under a
// configured modulus. Depends on mau_pkg.
`default_nettype none
// The unit takes one command while busy is low and answers with a single
// done strobe in the cycle in which busy drops; the receiver cannot stall,
// and a new command may be accepted in that same cycle. Operand reduction,
// division and multiplication run through one shared restoring
// divider/shift-add step, one bit per cycle. Every command first reduces
// operand_a, operand_b and the signed value, then passes a dispatch and a
// finish state. Multiply adds a shift-add pass. Inverse adds the check state
// and, per Euclid step, a division pass, a multiply pass and another check,
// with at most about 1.44*WIDTH steps. Divide adds the same Euclid steps
// plus its final multiply, which also runs when no inverse exists.
// The modulus write is always ready.
module modular_arithmetic_unit import mau_pkg::*; #(
	parameter int unsigned WIDTH = DEF_WIDTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire in_item_t  cmd,
	output logic           busy,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [31:0] cfg_data,
	output logic           done,
	output out_item_t      rsp
);
	localparam int unsigned CW = $clog2(64 + 1);
	typedef logic [WIDTH-1:0] w_t;

	state_t st_q, st_d;
	logic [31:0] mod_q;
	in_item_t cmd_q;
	w_t n_q, a_q, b_q, x_q, y_q, c0_q, c1_q, q_q, acc_q, mb_q, rem_q;
	logic [63:0] dv_q;
	logic [CW-1:0] cnt_q;
	logic neg_q, err_q, phase_q;
	out_item_t rsp_q;
	logic done_q;

	w_t nm;
	always_comb begin
		nm = w_t'(mod_q);
		if (nm == '0) nm = w_t'(1);
	end

	// shared step: restoring remainder bit and modular double/add
	logic [WIDTH:0] rsh, acc2;
	w_t rnext, dsor;
	logic qbit;
	always_comb begin
		dsor = (st_q == ST_EDIV) ? y_q : n_q;
		rsh = {rem_q, dv_q[63]};
		qbit = rsh >= {1'b0, dsor};
		rnext = qbit ? w_t'(rsh - {1'b0, dsor}) : w_t'(rsh);
		acc2 = {1'b0, acc_q} + {1'b0, acc_q};
		if (acc2 >= {1'b0, n_q}) acc2 = acc2 - {1'b0, n_q};
		if (mb_q[WIDTH-1]) begin
			acc2 = acc2 + {1'b0, a_q};
			if (acc2 >= {1'b0, n_q}) acc2 = acc2 - {1'b0, n_q};
		end
	end

	assign busy = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (start) st_d = ST_RDA;
			ST_RDA:  if (cnt_q == '0) st_d = ST_RDB;
			ST_RDB:  if (cnt_q == '0) st_d = ST_RDS;
			ST_RDS:  if (cnt_q == '0) st_d = ST_DISP;
			ST_DISP: begin
				unique case (op_t'(cmd_q.operation))
					OP_MUL: st_d = ST_MUL;
					OP_DIV, OP_INV: st_d = ST_ECHK;
					default: st_d = ST_DONE;
				endcase
			end
			ST_ECHK: st_d = (y_q == '0 || y_q == w_t'(1)) ?
				((phase_q) ? ST_MUL : ST_DONE) : ST_EDIV;
			ST_EDIV: if (cnt_q == '0) st_d = ST_EMUL;
			ST_EMUL: if (cnt_q == '0) st_d = ST_ECHK;
			ST_MUL:  if (cnt_q == '0) st_d = ST_DONE;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= 32'd1;
			done_q <= 1'b0;
		end else begin
			if (cfg_valid) mod_q <= cfg_data;
			done_q <= (st_q == ST_DONE);
		end
	end

	always_ff @(posedge clk) begin
		cnt_q <= cnt_q - CW'(1);
		dv_q <= {dv_q[62:0], 1'b0};
		rem_q <= rnext;
		q_q <= {q_q[WIDTH-2:0], qbit};
		acc_q <= w_t'(acc2);
		mb_q <= {mb_q[WIDTH-2:0], 1'b0};
		unique case (st_q)
			ST_IDLE: begin
				cmd_q <= cmd;
				n_q <= nm;
				rem_q <= '0;
				dv_q <= {w_t'(cmd.operand_a), {(64-WIDTH){1'b0}}};
				cnt_q <= CW'(WIDTH - 1);
				err_q <= 1'b0;
				phase_q <= 1'b0;
			end
			ST_RDA: if (cnt_q == '0) begin
				a_q <= rnext;
				rem_q <= '0;
				dv_q <= {w_t'(cmd_q.operand_b), {(64-WIDTH){1'b0}}};
				cnt_q <= CW'(WIDTH - 1);
			end
			ST_RDB: if (cnt_q == '0) begin
				b_q <= rnext;
				rem_q <= '0;
				neg_q <= cmd_q.signed_value[63];
				dv_q <= cmd_q.signed_value[63] ? (~cmd_q.signed_value + 64'd1)
					: cmd_q.signed_value;
				cnt_q <= CW'(63);
			end
			ST_RDS: if (cnt_q == '0) x_q <= rnext;
			ST_DISP: begin
				acc_q <= '0;
				cnt_q <= CW'(WIDTH - 1);
				unique case (op_t'(cmd_q.operation))
					OP_REDUCE: x_q <= (neg_q && x_q != '0) ? n_q - x_q : x_q;
					OP_ADD: x_q <= (a_q >= n_q - b_q) ? a_q - (n_q - b_q) : a_q + b_q;
					OP_SUB: x_q <= (a_q >= b_q) ? a_q - b_q : a_q + (n_q - b_q);
					OP_NEG: x_q <= (a_q == '0) ? '0 : n_q - a_q;
					OP_MUL: mb_q <= b_q;
					OP_DIV, OP_INV: begin
						phase_q <= (op_t'(cmd_q.operation) == OP_DIV);
						y_q <= (op_t'(cmd_q.operation) == OP_DIV) ? b_q : a_q;
						x_q <= n_q;
						c0_q <= '0;
						c1_q <= (n_q == w_t'(1)) ? '0 : w_t'(1);
						if (((op_t'(cmd_q.operation) == OP_DIV) ? b_q : a_q) == '0)
							err_q <= 1'b1;
					end
					default: x_q <= '0;
				endcase
			end
			ST_ECHK: begin
				cnt_q <= CW'(WIDTH - 1);
				rem_q <= '0;
				dv_q <= {x_q, {(64-WIDTH){1'b0}}};
				acc_q <= '0;
				if (y_q == '0 || err_q) err_q <= 1'b1;
				if (y_q == w_t'(1)) mb_q <= c1_q;
				x_q <= c1_q;
			end
			ST_EDIV: if (cnt_q == '0) begin
				// q < n always since x <= n and y >= 2
				x_q <= y_q;
				y_q <= rnext;
				mb_q <= {q_q[WIDTH-2:0], qbit};
				a_q <= c1_q;
				b_q <= a_q;
				cnt_q <= CW'(WIDTH - 1);
			end
			ST_EMUL: begin
				if (cnt_q == '0) begin
					c1_q <= (c0_q >= w_t'(acc2)) ? c0_q - w_t'(acc2)
						: c0_q + (n_q - w_t'(acc2));
					c0_q <= c1_q;
					a_q <= b_q;
				end
			end
			ST_MUL: if (cnt_q == '0) x_q <= w_t'(acc2);
			ST_DONE: begin
				rsp_q.result <= 32'(err_q ? '0 : x_q);
				rsp_q.is_equal <= (op_t'(cmd_q.operation) == OP_EQ) && (a_q == b_q);
				rsp_q.error_code <= err_q;
			end
			default: ;
		endcase
		if (st_q == ST_ECHK && y_q == w_t'(1) && phase_q) acc_q <= '0;
	end

	// a_q is parked in b_q during Euclid and restored after each step, so the
	// dividend of divide survives for the final multiply.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE && start) |=> st_q == ST_RDA) else $error("start lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.error_code && rsp.result != '0)) else $error("err result");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(st_q) == ST_DONE) else $error("stray done");
endmodule
`default_nettype wire

/* dv/modular_arithmetic_unit_tb.sv */
// Testbench for modular_arithmetic_unit: directed table, then random commands
// under several moduli, checked against a modular-arithmetic predictor.
// Depends on mau_pkg and the unit's RTL.
`timescale 1ns / 1ps
module modular_arithmetic_unit_tb;
	import mau_pkg::*;

	typedef struct {
		bit          wr_mod;
		logic [31:0] mod_val;
		op_t         op;
		logic [31:0] a;
		logic [31:0] b;
		logic [63:0] sv;
		bit          typed;
		out_item_t   rsp_exp;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	in_item_t cmd = '0;
	logic busy;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;
	logic done;
	out_item_t rsp;

	logic [31:0] modulus_q = 32'd1;
	out_item_t residue_q[$];
	int unsigned errors = 0;
	int unsigned idle_pct = 0;

	modular_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .rsp(rsp)
	);

	always #5 clk = ~clk;

	initial begin
		#200ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [63:0] inverse_of(logic [63:0] v, logic [63:0] n, output bit ok);
		longint r0, r1, t0, t1, q, tmp;
		r0 = longint'(n);
		r1 = longint'(v);
		t0 = 0;
		t1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			tmp = r0 - q * r1; r0 = r1; r1 = tmp;
			tmp = t0 - q * t1; t0 = t1; t1 = tmp;
		end
		ok = (v != 0) && (r0 == 1);
		t0 = t0 % longint'(n);
		if (t0 < 0)
			t0 += longint'(n);
		return ok ? 64'(t0) : '0;
	endfunction

	function automatic out_item_t residue_of(in_item_t it, logic [31:0] m);
		logic [63:0] n, a, b, mag, iv;
		bit ok;
		out_item_t o;
		n = (m == 0) ? 64'd1 : {32'd0, m};
		a = {32'd0, it.operand_a} % n;
		b = {32'd0, it.operand_b} % n;
		o = '0;
		case (op_t'(it.operation))
			OP_REDUCE: begin
				if (!it.signed_value[63]) begin
					o.result = 32'(it.signed_value % n);
				end else begin
					mag = (~it.signed_value) + 64'd1;
					mag = mag % n;
					o.result = 32'((mag == 0) ? 64'd0 : n - mag);
				end
			end
			OP_ADD: o.result = 32'((a + b) % n);
			OP_SUB: o.result = 32'((a + n - b) % n);
			OP_MUL: o.result = 32'((a * b) % n);
			OP_DIV: begin
				iv = inverse_of(b, n, ok);
				if (ok) o.result = 32'((a * iv) % n);
				else o.error_code = 1'b1;
			end
			OP_NEG: o.result = 32'((n - a) % n);
			OP_INV: begin
				iv = inverse_of(a, n, ok);
				if (ok) o.result = 32'(iv);
				else o.error_code = 1'b1;
			end
			default: o.is_equal = (a == b);
		endcase
		return o;
	endfunction

	always @(posedge clk) begin
		if (done) begin
			if (residue_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual %h/%b/%b", $time,
					rsp.result, rsp.is_equal, rsp.error_code);
			end else begin
				if (rsp !== residue_q[0]) begin
					errors++;
					$display("%0t: mismatch, expected %h/%b/%b actual %h/%b/%b", $time,
						residue_q[0].result, residue_q[0].is_equal, residue_q[0].error_code,
						rsp.result, rsp.is_equal, rsp.error_code);
				end
				void'(residue_q.pop_front());
			end
		end
	end

	task automatic wait_drained();
		while (residue_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_modulus(logic [31:0] v);
		wait_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		modulus_q = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// start stays high across back-to-back transfers
	task automatic send(in_item_t it, bit typed, out_item_t typed_rsp);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		cmd = it;
		do @(posedge clk); while (busy);
		residue_q.push_back(typed ? typed_rsp : residue_of(it, modulus_q));
		@(negedge clk);
	endtask

	task automatic send_random(logic [31:0] n);
		in_item_t it;
		it.operation = 3'($urandom_range(7));
		case ($urandom_range(3))
			0: begin
				it.operand_a = $urandom;
				it.operand_b = $urandom;
			end
			1: begin
				it.operand_a = (n == 0) ? 32'd0 : $urandom % n;
				it.operand_b = (n == 0) ? 32'd0 : $urandom % n;
			end
			2: begin
				it.operand_a = n - 32'($urandom_range(2));
				it.operand_b = n + 32'($urandom_range(2));
			end
			default: begin
				it.operand_a = $urandom_range(3);
				it.operand_b = $urandom_range(3);
			end
		endcase
		it.signed_value = $urandom_range(1) ? {$urandom, $urandom}
			: 64'(longint'($urandom_range(200)) - 100);
		send(it, 1'b0, '0);
	endtask

	localparam logic [31:0] MAXV = 32'hFFFF_FFFF;
	localparam out_item_t ZERO_RSP = '0;
	localparam out_item_t NOINV_RSP = '{result: 32'd0, is_equal: 1'b0, error_code: 1'b1};
	localparam out_item_t EQ_RSP = '{result: 32'd0, is_equal: 1'b1, error_code: 1'b0};

	vec_t vecs[] = '{
		'{0, 0, OP_REDUCE, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1, ZERO_RSP},
		'{0, 0, OP_ADD, MAXV, MAXV, 0, 1, ZERO_RSP},
		'{0, 0, OP_SUB, 0, MAXV, 0, 1, ZERO_RSP},
		'{0, 0, OP_MUL, MAXV, MAXV, 0, 1, ZERO_RSP},
		'{0, 0, OP_DIV, 7, 3, 0, 1, NOINV_RSP},
		'{0, 0, OP_NEG, 9, 0, 0, 1, ZERO_RSP},
		'{0, 0, OP_INV, 5, 0, 0, 1, NOINV_RSP},
		'{0, 0, OP_EQ, 3, 7, 0, 1, EQ_RSP},
		'{1, 0, OP_INV, 1, 0, 0, 1, NOINV_RSP},
		'{0, 0, OP_EQ, MAXV, 2, 0, 1, EQ_RSP},
		'{1, MAXV, OP_REDUCE, 0, 0, 64'h8000_0000_0000_0000, 0, ZERO_RSP},
		'{0, 0, OP_REDUCE, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, ZERO_RSP},
		'{0, 0, OP_ADD, MAXV - 1, MAXV - 1, 0, 0, ZERO_RSP},
		'{0, 0, OP_SUB, 0, MAXV - 1, 0, 0, ZERO_RSP},
		'{0, 0, OP_MUL, MAXV - 1, MAXV - 1, 0, 0, ZERO_RSP},
		'{0, 0, OP_DIV, 5, 3, 0, 1, NOINV_RSP},
		'{0, 0, OP_INV, 2, 0, 0, 0, ZERO_RSP},
		'{0, 0, OP_INV, MAXV, 0, 0, 1, NOINV_RSP},
		'{0, 0, OP_NEG, MAXV, 0, 0, 1, ZERO_RSP},
		'{0, 0, OP_NEG, 1, 0, 0, 0, ZERO_RSP},
		'{0, 0, OP_EQ, 0, MAXV, 0, 1, EQ_RSP},
		'{1, 97, OP_INV, 96, 0, 0, 0, ZERO_RSP},
		'{0, 0, OP_DIV, 10, 7, 0, 0, ZERO_RSP},
		'{0, 0, OP_EQ, 5, 102, 0, 1, EQ_RSP},
		'{1, 32'h8000_0000, OP_INV, 2, 0, 0, 1, NOINV_RSP}
	};

	initial begin
		in_item_t it;
		logic [31:0] n;
		int unsigned modes[4] = '{0, 81, 0, 14};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (vecs[i]) begin
			if (vecs[i].wr_mod) begin
				start = 1'b0;
				write_modulus(vecs[i].mod_val);
			end
			it.operation = vecs[i].op;
			it.operand_a = vecs[i].a;
			it.operand_b = vecs[i].b;
			it.signed_value = vecs[i].sv;
			send(it, vecs[i].typed, vecs[i].rsp_exp);
		end
		for (int p = 0; p < 12; p++) begin
			start = 1'b0;
			case (p % 6)
				0: n = 32'd1;
				1: n = MAXV;
				2: n = 32'd1 << $urandom_range(31);
				3: n = $urandom_range(1000, 2);
				4: n = $urandom_range(65521, 2);
				default: n = $urandom;
			endcase
			write_modulus(n);
			idle_pct = modes[p % 4];
			repeat (125) send_random(n);
		end
		start = 1'b0;
		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0 && residue_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
